// ===== rtl/gcl_pkg.sv =====
// Shared constants, types and helpers of the glyph cache.
package gcl_pkg;

  // Cache geometry
  localparam int SETS        = 256;
  localparam int WAYS        = 8;
  localparam int MAX_GLYPH   = 32;
  localparam int COUNT_BITS  = 16;
  localparam int SET_BITS    = $clog2(SETS);
  localparam int WAY_BITS    = $clog2(WAYS);
  localparam int SLOT_W      = 11;
  localparam int SLOT_FULL_W = SET_BITS + WAY_BITS;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

  // Queue depths
  localparam int QDEPTH = 2;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam logic REG_CACHE_ENABLE = 1'b0;

  // Request modes
  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_FILL   = 1'b1;

  typedef enum logic [1:0] {
    ST_HIT    = 2'd0,
    ST_MISS   = 2'd1,
    ST_BYPASS = 2'd2,
    ST_FILLED = 2'd3
  } status_t;

  typedef struct packed {
    logic               mode;
    logic [15:0]        char_code;
    logic [7:0]         text_size;
    logic signed [15:0] fill_advance;
    logic signed [7:0]  fill_left;
    logic signed [7:0]  fill_top;
    logic [5:0]         fill_rows;
    logic [5:0]         fill_width;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [SLOT_W-1:0]  slot_index;
    logic               evicted;
    logic signed [15:0] glyph_advance;
    logic signed [7:0]  glyph_left;
    logic signed [7:0]  glyph_top;
    logic [5:0]         glyph_rows;
    logic [5:0]         glyph_width;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] advance;
    logic signed [7:0]  left;
    logic signed [7:0]  top;
    logic [5:0]         rows;
    logic [5:0]         width;
  } metrics_t;

  typedef struct packed {
    logic [15:0] code;
    logic [7:0]  size;
  } tag_t;

  typedef struct packed {
    tag_t                  tag;
    logic [COUNT_BITS-1:0] count;
    metrics_t              metrics;
  } entry_t;

  typedef entry_t [WAYS-1:0] row_t;
  localparam int ROW_W = $bits(row_t);

  // Classified request between front and back
  typedef struct packed {
    logic     bypass;
    in_item_t item;
  } req_t;

  function automatic metrics_t fill_metrics(input in_item_t it);
    metrics_t m;
    m.advance = it.fill_advance;
    m.left    = it.fill_left;
    m.top     = it.fill_top;
    m.rows    = it.fill_rows;
    m.width   = it.fill_width;
    return m;
  endfunction

  function automatic out_item_t make_result(input status_t st,
                                            input logic [SLOT_W-1:0] slot,
                                            input logic ev,
                                            input metrics_t m);
    out_item_t r;
    r.status        = st;
    r.slot_index    = slot;
    r.evicted       = ev;
    r.glyph_advance = m.advance;
    r.glyph_left    = m.left;
    r.glyph_top     = m.top;
    r.glyph_rows    = m.rows;
    r.glyph_width   = m.width;
    return r;
  endfunction

endpackage

// ===== rtl/gcl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module gcl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/gcl_front.sv =====
// Front end: accepts requests, marks bypass cases, queues them for the back end.
module gcl_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cache_enable,
  input  logic              push,
  output logic              full,
  input  gcl_pkg::in_item_t request,
  output logic              q_valid,
  output gcl_pkg::req_t     q_data,
  input  logic              q_pop
);

  gcl_pkg::req_t q_mem [gcl_pkg::QDEPTH];
  logic          wp;
  logic          rp;
  logic [1:0]    cnt;
  logic          accept;
  gcl_pkg::req_t req_in;

  // Classify: disabled cache or oversize glyph goes around the cache
  always_comb begin
    req_in.item   = request;
    req_in.bypass = !cache_enable || (request.text_size > 8'(gcl_pkg::MAX_GLYPH));
  end

  assign full    = (cnt == 2'(gcl_pkg::QDEPTH));
  assign accept  = push && !full;
  assign q_valid = (cnt != 2'd0);
  assign q_data  = q_mem[rp];

  // Payload storage
  always_ff @(posedge clk) begin
    if (accept) begin
      q_mem[wp] <= req_in;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (accept) wp <= !wp;
      if (q_pop)  rp <= !rp;
      cnt <= cnt + 2'(accept) - 2'(q_pop);
    end
  end

endmodule

// ===== rtl/gcl_back.sv =====
// Back end: reads the set, matches tags, picks the LFU victim, writes back, queues results.
module gcl_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  gcl_pkg::req_t      q_data,
  output logic               q_pop,
  output logic               empty,
  input  logic               pop,
  output gcl_pkg::out_item_t result
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EVAL = 2'b10
  } state_t;

  state_t                        state;
  gcl_pkg::req_t                 cur;
  logic [gcl_pkg::SETS-1:0]      set_valid;
  logic                          row_valid;
  logic                          take;
  logic [gcl_pkg::SET_BITS-1:0]  take_set;
  logic [gcl_pkg::SET_BITS-1:0]  cur_set;
  gcl_pkg::row_t                 rdata;
  gcl_pkg::row_t                 row_eff;
  gcl_pkg::row_t                 new_row;
  gcl_pkg::tag_t                 cur_tag;
  logic                          hit;
  logic [gcl_pkg::WAY_BITS-1:0]  hit_way;
  logic [gcl_pkg::WAY_BITS-1:0]  vic;
  logic [gcl_pkg::WAY_BITS-1:0]  way;
  logic                          found;
  logic [gcl_pkg::COUNT_BITS-1:0] vmin;
  logic                          is_fill;
  logic                          ram_we;
  logic [gcl_pkg::SLOT_FULL_W-1:0] slot_full;
  gcl_pkg::out_item_t            eval_res;
  gcl_pkg::out_item_t            byp_res;
  gcl_pkg::out_item_t            res_in;
  logic                          res_push;
  gcl_pkg::out_item_t            res_mem [gcl_pkg::QDEPTH];
  logic                          res_wp;
  logic                          res_rp;
  logic [1:0]                    res_cnt;
  logic                          res_pop;

  // Take a new request only when a result slot is guaranteed
  assign take     = (state == S_IDLE) && q_valid && (res_cnt != 2'(gcl_pkg::QDEPTH));
  assign q_pop    = take;
  assign take_set = gcl_pkg::SET_BITS'(q_data.item.char_code);
  assign cur_set  = gcl_pkg::SET_BITS'(cur.item.char_code);

  // Set storage: one row holds all ways of a set
  gcl_ram #(
    .WIDTH (gcl_pkg::ROW_W),
    .DEPTH (gcl_pkg::SETS)
  ) u_set_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cur_set),
    .wdata (new_row),
    .re    (take && !q_data.bypass),
    .raddr (take_set),
    .rdata (rdata)
  );

  // Bypass result, built straight from the request
  always_comb begin
    byp_res = gcl_pkg::make_result(gcl_pkg::ST_BYPASS, '0, 1'b0,
                                   (q_data.item.mode == gcl_pkg::MODE_FILL) ?
                                   gcl_pkg::fill_metrics(q_data.item) : '0);
  end

  // Tag match, victim choice and row update
  always_comb begin
    row_eff       = row_valid ? rdata : '0;
    cur_tag.code  = cur.item.char_code;
    cur_tag.size  = cur.item.text_size;
    is_fill       = (cur.item.mode == gcl_pkg::MODE_FILL);
    hit           = 1'b0;
    hit_way       = '0;
    for (int w = 0; w < gcl_pkg::WAYS; w++) begin
      if (!hit && (row_eff[w].count != '0) && (row_eff[w].tag == cur_tag)) begin
        hit     = 1'b1;
        hit_way = gcl_pkg::WAY_BITS'(w);
      end
    end
    // first empty way, else lowest-indexed smallest count
    vic   = '0;
    vmin  = row_eff[0].count;
    found = 1'b0;
    for (int w = 0; w < gcl_pkg::WAYS; w++) begin
      if (!found) begin
        if (row_eff[w].count == '0) begin
          vic   = gcl_pkg::WAY_BITS'(w);
          found = 1'b1;
        end else if (row_eff[w].count < vmin) begin
          vic  = gcl_pkg::WAY_BITS'(w);
          vmin = row_eff[w].count;
        end
      end
    end
    way       = (is_fill && !hit) ? vic : hit_way;
    slot_full = gcl_pkg::SLOT_FULL_W'(cur_set) * gcl_pkg::SLOT_FULL_W'(gcl_pkg::WAYS)
              + gcl_pkg::SLOT_FULL_W'(way);
    new_row   = row_eff;
    if (is_fill) begin
      new_row[way].tag     = cur_tag;
      new_row[way].count   = gcl_pkg::COUNT_ONE;
      new_row[way].metrics = gcl_pkg::fill_metrics(cur.item);
      eval_res = gcl_pkg::make_result(gcl_pkg::ST_FILLED,
                                      gcl_pkg::SLOT_W'(slot_full),
                                      !hit && (row_eff[vic].count != '0),
                                      gcl_pkg::fill_metrics(cur.item));
    end else if (hit) begin
      if (row_eff[way].count != gcl_pkg::COUNT_MAX) begin
        new_row[way].count = row_eff[way].count + gcl_pkg::COUNT_ONE;
      end
      eval_res = gcl_pkg::make_result(gcl_pkg::ST_HIT, gcl_pkg::SLOT_W'(slot_full),
                                      1'b0, row_eff[way].metrics);
    end else begin
      eval_res = gcl_pkg::make_result(gcl_pkg::ST_MISS, '0, 1'b0, '0);
    end
    ram_we = (state == S_EVAL) && (is_fill || hit);
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (take && !q_data.bypass) state <= S_EVAL;
        end
        S_EVAL: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Request and set-valid capture
  always_ff @(posedge clk) begin
    if (take) begin
      cur       <= q_data;
      row_valid <= set_valid[take_set];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      set_valid <= '0;
    end else if (ram_we) begin
      set_valid[cur_set] <= 1'b1;
    end
  end

  // Result queue
  assign res_push = (take && q_data.bypass) || (state == S_EVAL);
  assign res_in   = (state == S_EVAL) ? eval_res : byp_res;
  assign empty    = (res_cnt == 2'd0);
  assign res_pop  = pop && !empty;
  assign result   = res_mem[res_rp];

  always_ff @(posedge clk) begin
    if (res_push) begin
      res_mem[res_wp] <= res_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_wp  <= 1'b0;
      res_rp  <= 1'b0;
      res_cnt <= 2'd0;
    end else begin
      if (res_push) res_wp <= !res_wp;
      if (res_pop)  res_rp <= !res_rp;
      res_cnt <= res_cnt + 2'(res_push) - 2'(res_pop);
    end
  end

  // Checks
  a_res_bound: assert property (@(posedge clk) disable iff (rst)
    res_cnt <= 2'(gcl_pkg::QDEPTH))
    else $error("result queue overflow");

  a_we_eval: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_EVAL))
    else $error("set write outside evaluation");

  a_eval_once: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL) |=> (state == S_IDLE))
    else $error("evaluation lasted more than one cycle");

  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL) |-> !q_pop)
    else $error("request taken while busy");

endmodule

// ===== rtl/glyph_cache_lfu_unit.sv =====
// Top level of the glyph metrics cache: configuration register, front and back end.
// In the back end, a lookup or fill that reaches the cache first reads the
// whole set from the set RAM into a register, then matches tags, chooses the
// least-frequently-used victim and writes the row back. A bypassed request
// goes straight to the result queue. Requests and results each pass through a
// two-entry queue, so the block keeps accepting while results wait. Per-set
// valid flags make an untouched set read as empty, with no clearing after reset.
module glyph_cache_lfu_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  gcl_pkg::in_item_t             request,
  output logic                          empty,
  input  logic                          pop,
  output gcl_pkg::out_item_t            result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gcl_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  logic          cache_enable;
  logic          q_valid;
  logic          q_pop;
  gcl_pkg::req_t q_data;
  logic          reg_sel;

  // Configuration register
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == gcl_pkg::REG_CACHE_ENABLE);
  assign prdata  = reg_sel ? {31'd0, cache_enable} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cache_enable <= 1'b1;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      cache_enable <= pwdata[0];
    end
  end

  gcl_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cache_enable (cache_enable),
    .push         (push),
    .full         (full),
    .request      (request),
    .q_valid      (q_valid),
    .q_data       (q_data),
    .q_pop        (q_pop)
  );

  gcl_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule
